### rtl/core/max_repeat_count_macros.svh
// Assertion macros for the max repeat count block.
`ifndef MAX_REPEAT_COUNT_MACROS_SVH
`define MAX_REPEAT_COUNT_MACROS_SVH

// check a property on every clock edge outside reset
`define MRC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// check that a condition leads to another in the next cycle
`define MRC_ASSERT_NEXT(lbl, cond, nxt, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (nxt)) else $error(msg);

`endif

### rtl/core/mrc_pkg.sv
// Shared types and constants of the max repeat count block.
package mrc_pkg;

    localparam int DEPTH_DEF = 256;
    localparam int VAL_W     = 32;
    localparam int CNT_W     = 9;
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic signed [VAL_W-1:0] element_value;
        logic                    is_last;
    } t_in_item;

    typedef struct packed {
        logic [CNT_W-1:0] max_count;
        logic             overflowed;
    } t_out_item;

endpackage

### rtl/core/max_repeat_count.sv
// Top level of the max repeat count block.
//
// Requests on the input channel carry one element of a set and a last flag.
// Elements load into the element store at one request per cycle. The
// request flagged last closes the set; input ready then drops while every
// stored element is compared with every one, itself included, one pair per
// cycle through the two read ports of the store, and then through the wait
// and done states. The result becomes valid on the output channel after the
// last request is accepted, as input ready returns. It carries the highest
// count of any value (saturating at 511) and a flag for dropped elements.
// Elements that arrive while the store holds DEPTH entries are dropped.
// The output register holds its request while the receiver stalls; loading
// of the next set goes on meanwhile, and a further result waits for it.
// Reset empties the store and clears the drop flag and the output valid.
module max_repeat_count #(
    parameter int DEPTH = mrc_pkg::DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mrc_pkg::t_in_item   i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output mrc_pkg::t_out_item  o_out
);
    import mrc_pkg::*;

    `include "max_repeat_count_macros.svh"

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic             we;
    logic [AW-1:0]    waddr;
    logic [VAL_W-1:0] wdata;
    logic [AW-1:0]    raddr_a;
    logic [AW-1:0]    raddr_b;
    logic [VAL_W-1:0] rdata_a;
    logic [VAL_W-1:0] rdata_b;
    logic             last_acc;

    mrc_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    mrc_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_raddr_a   (raddr_a),
        .o_raddr_b   (raddr_b),
        .i_rdata_a   (rdata_a),
        .i_rdata_b   (rdata_b)
    );

    assign last_acc = i_in_valid && o_in_ready && i_in.is_last;

    `MRC_ASSERT(a_count_nonzero, o_out_valid |-> (o_out.max_count != '0), "empty count shown")
    `MRC_ASSERT_NEXT(a_last_blocks, last_acc, !o_in_ready, "input open after last")
    `MRC_ASSERT_NEXT(a_no_instant_result, last_acc && !o_out_valid, !o_out_valid, "result too early")

endmodule

### rtl/core/mrc_mem.sv
// Element store: one write port, two registered read ports.
module mrc_mem #(
    parameter int DEPTH = mrc_pkg::DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [AW-1:0]                i_waddr,
    input  logic [mrc_pkg::VAL_W-1:0]    i_wdata,
    input  logic [AW-1:0]                i_raddr_a,
    input  logic [AW-1:0]                i_raddr_b,
    output logic [mrc_pkg::VAL_W-1:0]    o_rdata_a,
    output logic [mrc_pkg::VAL_W-1:0]    o_rdata_b
);
    import mrc_pkg::*;

    logic [VAL_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

### rtl/core/mrc_ctrl.sv
// Load sequencer, all-pairs scan and result register.
module mrc_ctrl #(
    parameter int DEPTH = mrc_pkg::DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  mrc_pkg::t_in_item            i_in,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output mrc_pkg::t_out_item           o_out,
    output logic                         o_we,
    output logic [AW-1:0]                o_waddr,
    output logic [mrc_pkg::VAL_W-1:0]    o_wdata,
    output logic [AW-1:0]                o_raddr_a,
    output logic [AW-1:0]                o_raddr_b,
    input  logic [mrc_pkg::VAL_W-1:0]    i_rdata_a,
    input  logic [mrc_pkg::VAL_W-1:0]    i_rdata_b
);
    import mrc_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = CW + CNT_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    localparam logic [1:0] S_LOAD = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_fill, n_fill;
    logic          r_ovf, n_ovf;
    logic [AW-1:0] r_i, n_i;
    logic [AW-1:0] r_j, n_j;
    logic          r_p_valid, n_p_valid;
    logic          r_p_first, n_p_first;
    logic          r_p_lastj, n_p_lastj;
    logic          r_p_last, n_p_last;
    logic [CW-1:0] r_hits, n_hits;
    logic [CW-1:0] r_best, n_best;
    logic          r_out_valid, n_out_valid;
    t_out_item     r_out, n_out;

    logic          accept;
    logic [AW-1:0] last_idx;
    logic [CW-1:0] fill_m1;
    logic [CW-1:0] hits_sum;
    logic [XW-1:0] best_ext;
    logic          end_j;
    logic          end_i;

    assign o_in_ready  = (r_state == S_LOAD);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign o_we      = accept && (r_fill < DEPTH_C);
    assign o_waddr   = r_fill[AW-1:0];
    assign o_wdata   = i_in.element_value;
    assign o_raddr_a = r_i;
    assign o_raddr_b = r_j;

    assign fill_m1  = r_fill - CW'(1);
    assign last_idx = fill_m1[AW-1:0];
    assign end_j    = (r_j == last_idx);
    assign end_i    = (r_i == last_idx);
    assign hits_sum = (r_p_first ? '0 : r_hits) + CW'(i_rdata_a == i_rdata_b);
    assign best_ext = {{CNT_W{1'b0}}, r_best};

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_ovf       = r_ovf;
        n_i         = r_i;
        n_j         = r_j;
        n_p_valid   = 1'b0;
        n_p_first   = 1'b0;
        n_p_lastj   = 1'b0;
        n_p_last    = 1'b0;
        n_hits      = r_hits;
        n_best      = r_best;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;

        if (r_p_valid) begin
            n_hits = hits_sum;
            if (r_p_lastj && (hits_sum > r_best)) begin
                n_best = hits_sum;
            end
        end

        unique case (r_state)
            S_LOAD: begin
                if (accept) begin
                    if (r_fill < DEPTH_C) begin
                        n_fill = r_fill + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in.is_last) begin
                        n_state = S_SCAN;
                        n_i     = '0;
                        n_j     = '0;
                        n_best  = '0;
                    end
                end
            end
            S_SCAN: begin
                n_p_valid = 1'b1;
                n_p_first = (r_j == '0);
                n_p_lastj = end_j;
                n_p_last  = end_j && end_i;
                if (end_j) begin
                    n_j = '0;
                    n_i = r_i + AW'(1);
                    if (end_i) begin
                        n_state = S_WAIT;
                    end
                end else begin
                    n_j = r_j + AW'(1);
                end
            end
            S_WAIT: begin
                if (r_p_valid && r_p_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out.max_count = (best_ext > XW'(COUNT_MAX)) ? COUNT_MAX
                                                                  : best_ext[CNT_W-1:0];
                    n_out.overflowed = r_ovf;
                    n_fill  = '0;
                    n_ovf   = 1'b0;
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_fill      <= '0;
            r_ovf       <= 1'b0;
            r_p_valid   <= 1'b0;
            r_p_first   <= 1'b0;
            r_p_lastj   <= 1'b0;
            r_p_last    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_ovf       <= n_ovf;
            r_p_valid   <= n_p_valid;
            r_p_first   <= n_p_first;
            r_p_lastj   <= n_p_lastj;
            r_p_last    <= n_p_last;
            r_out_valid <= n_out_valid;
        end
        r_i    <= n_i;
        r_j    <= n_j;
        r_hits <= n_hits;
        r_best <= n_best;
        r_out  <= n_out;
    end

endmodule
